[design/bfd_pkg.sv]
// bfd_pkg: shared types, register indexes and fixed-point constants
// for the cubic B-spline forward-difference block; no dependencies
package bfd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   // configuration register indexes
   localparam logic CSR_STEP_COUNT = 1'b0;
   localparam logic CSR_STEP_SIZE  = 1'b1;

   localparam logic [5:0]  STEP_COUNT_RESET = 6'd16;
   localparam logic [15:0] STEP_SIZE_RESET  = 16'd4096;

   // setup sequence of the shared multiplier
   localparam logic [3:0] OP_H2   = 4'd0;
   localparam logic [3:0] OP_H3   = 4'd1;
   localparam logic [3:0] OP_X_A  = 4'd2;
   localparam logic [3:0] OP_X_B  = 4'd3;
   localparam logic [3:0] OP_X_C  = 4'd4;
   localparam logic [3:0] OP_Y_A  = 4'd5;
   localparam logic [3:0] OP_Y_B  = 4'd6;
   localparam logic [3:0] OP_Y_C  = 4'd7;
   localparam logic [3:0] OP_Z_A  = 4'd8;
   localparam logic [3:0] OP_Z_B  = 4'd9;
   localparam logic [3:0] OP_Z_C  = 4'd10;
   localparam logic [3:0] OP_LAST = 4'd11;

   localparam int LANES = 3;

   typedef enum logic [1:0] {
      KIND_A = 2'd0,
      KIND_B = 2'd1,
      KIND_C = 2'd2
   } kind_type;

   typedef struct packed {
      logic     is_lane;
      logic [1:0] lane;
      kind_type kind;
   } op_info_type;

   // output conversion: floor((s0 + 3*2^16) / (3*2^17))
   localparam logic [64:0] OUT_HALF   = 65'd196608;
   localparam logic signed [47:0] U_MIN = -48'sd6442450944;
   localparam logic signed [47:0] U_MAX = 48'sd6442450943;
   localparam logic [33:0] W_MAX      = 34'd12884901887;
   // 2^17 = 3 * DIV3_HI + 2
   localparam logic [15:0] DIV3_HI    = 16'd43690;
   // ceil(2^21 / 3)
   localparam logic [19:0] DIV3_RECIP = 20'd699051;

   function automatic op_info_type op_decode(input logic [3:0] op);
      op_info_type info;
      info = '{is_lane: 1'b1, lane: 2'd0, kind: KIND_A};
      case (op)
         OP_X_A: info = '{is_lane: 1'b1, lane: 2'd0, kind: KIND_A};
         OP_X_B: info = '{is_lane: 1'b1, lane: 2'd0, kind: KIND_B};
         OP_X_C: info = '{is_lane: 1'b1, lane: 2'd0, kind: KIND_C};
         OP_Y_A: info = '{is_lane: 1'b1, lane: 2'd1, kind: KIND_A};
         OP_Y_B: info = '{is_lane: 1'b1, lane: 2'd1, kind: KIND_B};
         OP_Y_C: info = '{is_lane: 1'b1, lane: 2'd1, kind: KIND_C};
         OP_Z_A: info = '{is_lane: 1'b1, lane: 2'd2, kind: KIND_A};
         OP_Z_B: info = '{is_lane: 1'b1, lane: 2'd2, kind: KIND_B};
         OP_Z_C: info = '{is_lane: 1'b1, lane: 2'd2, kind: KIND_C};
         default: info = '{is_lane: 1'b0, lane: 2'd0, kind: KIND_A};
      endcase
      return info;
   endfunction

   // clamp and offset an accumulator to a 34-bit unsigned dividend
   function automatic logic [33:0] conv_w(input logic [63:0] s);
      logic signed [64:0] v;
      logic signed [47:0] u;
      logic [47:0] diff;
      v = $signed({s[63], s}) + $signed(OUT_HALF);
      u = $signed(v[64:17]);
      diff = u - U_MIN;
      if (u < U_MIN) begin
         return 34'd0;
      end else if (u > U_MAX) begin
         return W_MAX;
      end
      return diff[33:0];
   endfunction

endpackage

[design/bspline_forward_difference.sv]
// bspline_forward_difference: uniform cubic B-spline evaluator by forward differences
// uses bfd_pkg for state, register codes and conversion constants
//
// Control points enter on the req_ channel (valid/ready). The first three
// points of a curve only fill the window. Every later point closes a
// window of four and starts a segment: a setup sequence on the shared
// multiplier (h^2, h^3, then three products per coordinate), then one
// curve point per cycle from the difference adders while rsp_ does not
// stall, step_count+1 points in all, the last with rsp_segment_end set.
// req_ready stays low through setup and run; results leave through a
// three-stage output conversion (clamp and offset, partial quotients by
// three, sum and offset removal). req_ready returns once the last point
// has entered the conversion pipeline, so the next point's setup overlaps
// the drain. A stall on rsp_ready freezes the conversion pipeline and the
// run; no point is lost. Reset (synchronous, active high) empties the
// window and the pipeline and loads step_count 16 and step_size 4096.
// csr_ writes are taken at once; the user must make them only while the
// block is idle, which the block itself does not enforce.
module bspline_forward_difference #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [15:0]                   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_new_curve,
   input  logic signed [COORD_WIDTH-1:0] req_px,
   input  logic signed [COORD_WIDTH-1:0] req_py,
   input  logic signed [COORD_WIDTH-1:0] req_pz,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_out_z,
   output logic                          rsp_segment_end
);
   import bfd_pkg::*;

   localparam int CW = COORD_WIDTH + 4;
   localparam int MUL_A_W = 33;

   state_type state_ff, state_in;
   logic [3:0] op_ff;
   logic [5:0] k_ff;
   logic [1:0] fill_ff;
   logic [5:0] step_count_ff;
   logic [15:0] step_size_ff;

   logic signed [COORD_WIDTH-1:0] win_ff [LANES][3];
   logic signed [CW-1:0] a6_ff [LANES];
   logic signed [CW-1:0] b6_ff [LANES];
   logic signed [CW-1:0] c6_ff [LANES];
   logic [63:0] s0_ff [LANES];
   logic [63:0] s1_ff [LANES];
   logic [63:0] s2_ff [LANES];
   logic [63:0] s3_ff [LANES];
   logic [31:0] h2_ff, h3_ff;
   logic [63:0] prod_ff;
   logic acc_valid_ff;
   logic [1:0] acc_lane_ff;
   kind_type acc_kind_ff;

   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic a_end_ff, b_end_ff, out_end_ff;
   logic [33:0] a_w_ff [LANES];
   logic [32:0] b_p1_ff [LANES];
   logic [17:0] b_q2_ff [LANES];
   logic [31:0] out_ff [LANES];

   logic accept, start, en, issue, last_issue;
   logic [1:0] fill_eff;
   logic signed [COORD_WIDTH-1:0] pt [LANES];
   logic signed [CW-1:0] a6_in [LANES];
   logic signed [CW-1:0] b6_in [LANES];
   logic signed [CW-1:0] c6_in [LANES];
   logic signed [CW-1:0] d6_in [LANES];
   op_info_type op_info;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [31:0] mul_b;
   logic signed [65:0] mul_p;
   logic [63:0] six_prod;

   assign pt[0] = req_px;
   assign pt[1] = req_py;
   assign pt[2] = req_pz;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign fill_eff = req_new_curve ? 2'd0 : fill_ff;
   assign start = accept && (fill_eff == 2'd3);
   assign en = !rsp_valid_ff || rsp_ready;
   assign issue = (state_ff == ST_RUN) && en;
   assign last_issue = issue && (k_ff == step_count_ff);

   // basis matrix times six, from the held window and the new point
   always_comb begin
      logic signed [CW-1:0] p0, p1, p2, p3;
      for (int l = 0; l < LANES; l++) begin
         p0 = CW'(win_ff[l][0]);
         p1 = CW'(win_ff[l][1]);
         p2 = CW'(win_ff[l][2]);
         p3 = CW'(pt[l]);
         a6_in[l] = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
         b6_in[l] = (p0 <<< 1) + p0 - (p1 <<< 2) - (p1 <<< 1) + (p2 <<< 1) + p2;
         c6_in[l] = ((p2 - p0) <<< 1) + (p2 - p0);
         d6_in[l] = p0 + (p1 <<< 2) + p2;
      end
   end

   // shared multiplier operand select
   assign op_info = op_decode(op_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (op_ff == OP_H2) begin
         mul_a = MUL_A_W'({1'b0, step_size_ff});
         mul_b = {16'd0, step_size_ff};
      end else if (op_ff == OP_H3) begin
         mul_a = MUL_A_W'({1'b0, h2_ff});
         mul_b = {16'd0, step_size_ff};
      end else if (op_info.is_lane) begin
         case (op_info.kind)
            KIND_A: begin
               mul_a = MUL_A_W'(a6_ff[op_info.lane]);
               mul_b = h3_ff;
            end
            KIND_B: begin
               mul_a = MUL_A_W'(b6_ff[op_info.lane]);
               mul_b = h2_ff;
            end
            KIND_C: begin
               mul_a = MUL_A_W'(c6_ff[op_info.lane]);
               mul_b = {16'd0, step_size_ff};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign mul_p = 66'(mul_a) * 66'($signed({1'b0, mul_b}));
   assign six_prod = (prod_ff << 2) + (prod_ff << 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (op_ff == OP_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_H2;
         k_ff <= '0;
         fill_ff <= '0;
         step_count_ff <= STEP_COUNT_RESET;
         step_size_ff <= STEP_SIZE_RESET;
         acc_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_COUNT: step_count_ff <= csr_wdata[5:0];
               CSR_STEP_SIZE:  step_size_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            fill_ff <= (fill_eff == 2'd3) ? 2'd3 : fill_eff + 2'd1;
         end
         if (start) begin
            op_ff <= OP_H2;
         end else if (state_ff == ST_SETUP) begin
            op_ff <= op_ff + 4'd1;
         end
         acc_valid_ff <= (state_ff == ST_SETUP) && op_info.is_lane;
         if (state_ff == ST_SETUP) begin
            k_ff <= '0;
         end else if (issue) begin
            k_ff <= k_ff + 6'd1;
         end
         if (en) begin
            a_valid_ff <= issue;
            b_valid_ff <= a_valid_ff;
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int l = 0; l < LANES; l++) begin
            if (fill_eff == 2'd3) begin
               win_ff[l][0] <= win_ff[l][1];
               win_ff[l][1] <= win_ff[l][2];
               win_ff[l][2] <= pt[l];
            end else begin
               win_ff[l][fill_eff] <= pt[l];
            end
            a6_ff[l] <= a6_in[l];
            b6_ff[l] <= b6_in[l];
            c6_ff[l] <= c6_in[l];
            s0_ff[l] <= {{(32 - CW){d6_in[l][CW-1]}}, d6_in[l], 32'd0};
         end
      end
      if (state_ff == ST_SETUP) begin
         if (op_ff == OP_H2) begin
            h2_ff <= mul_p[31:0];
         end
         if (op_ff == OP_H3) begin
            h3_ff <= mul_p[47:16];
         end
         prod_ff <= mul_p[63:0];
         acc_lane_ff <= op_info.lane;
         acc_kind_ff <= op_info.kind;
      end
      if (acc_valid_ff) begin
         case (acc_kind_ff)
            KIND_A: begin
               s1_ff[acc_lane_ff] <= prod_ff;
               s2_ff[acc_lane_ff] <= six_prod;
               s3_ff[acc_lane_ff] <= six_prod;
            end
            KIND_B: begin
               s1_ff[acc_lane_ff] <= s1_ff[acc_lane_ff] + prod_ff;
               s2_ff[acc_lane_ff] <= s2_ff[acc_lane_ff] + (prod_ff << 1);
            end
            KIND_C: begin
               s1_ff[acc_lane_ff] <= s1_ff[acc_lane_ff] + (prod_ff << 16);
            end
            default: ;
         endcase
      end
      if (issue) begin
         for (int l = 0; l < LANES; l++) begin
            s0_ff[l] <= s0_ff[l] + s1_ff[l];
            s1_ff[l] <= s1_ff[l] + s2_ff[l];
            s2_ff[l] <= s2_ff[l] + s3_ff[l];
         end
      end
      if (en) begin
         a_end_ff <= (k_ff == step_count_ff);
         b_end_ff <= a_end_ff;
         out_end_ff <= b_end_ff;
         for (int l = 0; l < LANES; l++) begin
            logic [16:0] wh;
            logic [18:0] x;
            logic [38:0] p2;
            logic [33:0] q;
            wh = a_w_ff[l][33:17];
            x = {1'b0, wh, 1'b0} + {2'b00, a_w_ff[l][16:0]};
            p2 = {20'd0, x} * {19'd0, DIV3_RECIP};
            q = {1'b0, b_p1_ff[l]} + {16'd0, b_q2_ff[l]};
            a_w_ff[l] <= conv_w(s0_ff[l]);
            b_p1_ff[l] <= {16'd0, wh} * {17'd0, DIV3_HI};
            b_q2_ff[l] <= p2[38:21];
            out_ff[l] <= {~q[31], q[30:0]};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_segment_end = out_end_ff;

   a_start_setup: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_SETUP) && (op_ff == OP_H2))
      else $error("segment start did not enter setup");

   a_setup_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> (op_ff <= OP_LAST))
      else $error("setup sequence ran past its last op");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      last_issue |=> (state_ff == ST_IDLE) && a_valid_ff && a_end_ff)
      else $error("last point of a segment not marked or run not ended");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && (state_ff == ST_RUN)) |=>
         $stable(a_valid_ff) && $stable(b_valid_ff) && $stable(k_ff))
      else $error("pipeline moved during output stall");

   a_no_acc_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !acc_valid_ff)
      else $error("setup accumulate overlaps the run");

endmodule

[sim/tb_bspline_forward_difference.sv]
// tb_bspline_forward_difference: self-checking testbench for the cubic B-spline
// forward-difference block: directed table, then random curves under random stalls
// depends on bfd_pkg and bspline_forward_difference
module tb_bspline_forward_difference;
   import bfd_pkg::*;

   localparam int    RANDOM_ITEMS  = 250;
   localparam int    SETTLE_CYCLES = 24;
   localparam int    CYCLE_LIMIT   = 3000000;
   localparam int    MAX_REPORTS   = 10;
   localparam longint ACC_CLAMP    = 64'sh4000_0000_0000_0000;
   localparam longint Q16_HALF     = 64'sd196608;
   localparam longint Q16_DIV      = 64'sd393216;
   localparam longint Q16_MAX      = 64'sd2147483647;
   localparam longint Q16_MIN      = -64'sd2147483648;

   typedef logic [63:0] acc_type;

   typedef struct packed {
      acc_type s0;
      acc_type s1;
      acc_type s2;
      acc_type s3;
   } diff_state_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               seg_end;
   } curve_point_type;

   typedef struct packed {
      logic               cfg_set;
      logic [5:0]         cfg_count;
      logic [15:0]        cfg_size;
      logic               new_curve;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               typed;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } point_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_STEP_COUNT;
   logic [15:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_new_curve = 1'b0;
   logic signed [15:0] req_px = '0;
   logic signed [15:0] req_py = '0;
   logic signed [15:0] req_pz = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_segment_end;

   // predictor state
   logic signed [15:0] ctrl_x [3];
   logic signed [15:0] ctrl_y [3];
   logic signed [15:0] ctrl_z [3];
   int                 ctrl_fill = 0;
   logic [5:0]         seg_steps = STEP_COUNT_RESET;
   logic [15:0]        seg_delta = STEP_SIZE_RESET;

   curve_point_type    expected_points [$];
   curve_point_type    next_point;
   point_row_type      directed_rows [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int points_checked = 0;
   int segments_seen  = 0;
   int items_sent     = 0;
   int settings_used  = 0;
   int sink_wait      = 0;
   int sink_stall_pct = 20;
   bit src_calm       = 1'b0;

   bspline_forward_difference dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_new_curve   (req_new_curve),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_segment_end (rsp_segment_end)
   );

   always #5 clock = ~clock;

   function automatic diff_state_type seed_diffs(input logic signed [15:0] p0, p1, p2, p3,
                                                 input acc_type h, h2, h3);
      longint         a6, b6, c6, d6;
      diff_state_type d;
      a6 = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
      b6 = 3 * longint'(p0) - 6 * longint'(p1) + 3 * longint'(p2);
      c6 = -3 * longint'(p0) + 3 * longint'(p2);
      d6 = longint'(p0) + 4 * longint'(p1) + longint'(p2);
      d.s0 = acc_type'(d6) << 32;
      d.s1 = acc_type'(a6) * h3 + acc_type'(b6) * h2 + acc_type'(c6) * h * 64'd65536;
      d.s2 = 64'd6 * acc_type'(a6) * h3 + 64'd2 * acc_type'(b6) * h2;
      d.s3 = 64'd6 * acc_type'(a6) * h3;
      return d;
   endfunction

   function automatic diff_state_type step_diffs(input diff_state_type d);
      d.s0 = d.s0 + d.s1;
      d.s1 = d.s1 + d.s2;
      d.s2 = d.s2 + d.s3;
      return d;
   endfunction

   // clamp, round half up to Q16.16, saturate
   function automatic logic signed [31:0] to_q16(input acc_type acc);
      longint v;
      longint q;
      v = acc;
      if (v > ACC_CLAMP) v = ACC_CLAMP;
      if (v < -ACC_CLAMP) v = -ACC_CLAMP;
      v = v + Q16_HALF;
      q = v / Q16_DIV;
      if ((v % Q16_DIV) != 0 && v < 0) q = q - 1;
      if (q > Q16_MAX) q = Q16_MAX;
      if (q < Q16_MIN) q = Q16_MIN;
      return q[31:0];
   endfunction

   task automatic predict_point(input logic nc, input logic signed [15:0] x, y, z,
                                input logic typed, input logic signed [31:0] tx, ty, tz);
      diff_state_type  dx, dy, dz;
      acc_type         h, h2, h3;
      curve_point_type pt;
      if (nc) ctrl_fill = 0;
      if (ctrl_fill == 3) begin
         h  = acc_type'(seg_delta);
         h2 = h * h;
         h3 = (h2 * h) >> 16;
         dx = seed_diffs(ctrl_x[0], ctrl_x[1], ctrl_x[2], x, h, h2, h3);
         dy = seed_diffs(ctrl_y[0], ctrl_y[1], ctrl_y[2], y, h, h2, h3);
         dz = seed_diffs(ctrl_z[0], ctrl_z[1], ctrl_z[2], z, h, h2, h3);
         for (int k = 0; k <= int'(seg_steps); k++) begin
            if (k > 0) begin
               dx = step_diffs(dx);
               dy = step_diffs(dy);
               dz = step_diffs(dz);
            end
            pt.x = typed ? tx : to_q16(dx.s0);
            pt.y = typed ? ty : to_q16(dy.s0);
            pt.z = typed ? tz : to_q16(dz.s0);
            pt.seg_end = (k == int'(seg_steps));
            expected_points = {expected_points, pt};
         end
      end
      if (ctrl_fill < 3) begin
         ctrl_x[ctrl_fill] = x;
         ctrl_y[ctrl_fill] = y;
         ctrl_z[ctrl_fill] = z;
         ctrl_fill++;
      end else begin
         ctrl_x = '{ctrl_x[1], ctrl_x[2], x};
         ctrl_y = '{ctrl_y[1], ctrl_y[2], y};
         ctrl_z = '{ctrl_z[1], ctrl_z[2], z};
      end
   endtask

   function automatic void add_row(input bit cs, input int cnt, input int sz,
                                   input bit nc, input int x, input int y,
                                   input int z, input bit typed,
                                   input logic [31:0] tx, ty, tz);
      point_row_type row;
      row.cfg_set   = cs;
      row.cfg_count = 6'(cnt);
      row.cfg_size  = 16'(sz);
      row.new_curve = nc;
      row.x         = 16'(x);
      row.y         = 16'(y);
      row.z         = 16'(z);
      row.typed     = typed;
      row.tx        = tx;
      row.ty        = ty;
      row.tz        = tz;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic logic signed [15:0] rand_coord();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         v = int'($urandom_range(0, 400)) - 200;
         return 16'(v);
      end else if (r < 85) begin
         return 16'($urandom());
      end
      case ($urandom_range(0, 3))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want)
         note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endfunction

   task automatic set_config(input int cnt, input int sz);
      csr_we    <= 1'b1;
      csr_index <= CSR_STEP_COUNT;
      csr_wdata <= {10'($urandom()), 6'(cnt)};
      @(posedge clock);
      csr_index <= CSR_STEP_SIZE;
      csr_wdata <= 16'(sz);
      @(posedge clock);
      csr_we <= 1'b0;
      seg_steps = 6'(cnt);
      seg_delta = 16'(sz);
      settings_used++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic idle_source();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = 0;
      if (!src_calm) begin
         if (r < 3) n = $urandom_range(15, 50);
         else if (r < 28) n = $urandom_range(1, 3);
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_point(input logic nc, input logic signed [15:0] x, y, z,
                             input logic typed, input logic signed [31:0] tx, ty, tz);
      req_valid     <= 1'b1;
      req_new_curve <= nc;
      req_px        <= x;
      req_py        <= y;
      req_pz        <= z;
      do @(posedge clock); while (!req_ready);
      predict_point(nc, x, y, z, typed, tx, ty, tz);
      items_sent++;
   endtask

   // result sink with random stalls
   always @(posedge clock) begin
      if (sink_wait > 0) begin
         rsp_ready <= 1'b0;
         sink_wait <= sink_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < sink_stall_pct)
            sink_wait <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
      if ($urandom_range(0, 255) == 0)
         sink_stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
   end

   // result checker: each transfer against the oldest expected point
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            note_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d end=%0b",
                                    rsp_out_x, rsp_out_y, rsp_out_z, rsp_segment_end));
         end else begin
            next_point = expected_points.pop_front();
            check_field("out_x", next_point.x, rsp_out_x);
            check_field("out_y", next_point.y, rsp_out_y);
            check_field("out_z", next_point.z, rsp_out_z);
            check_field("segment_end", next_point.seg_end, rsp_segment_end);
            points_checked++;
            if (rsp_segment_end) segments_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points still expected",
                  cycle_count, expected_points.size());
         $display("bspline_forward_difference regression: fail");
         $finish;
      end
   end

   initial begin
      int            random_items;
      int            phase_items;
      int            curve_len;
      int            cnt;
      int            sz;
      int            r;
      bit            noise;
      bit            paused_once;
      logic          nc;
      point_row_type row;

      random_items = 0;
      paused_once  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ctrl_x[i] = '0;
         ctrl_y[i] = '0;
         ctrl_z[i] = '0;
      end

      // after reset, four zero points give all-zero curve points
      add_row(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      // four equal extreme points give a constant curve
      add_row(0, 0, 0, 1, 32767, -32768, 32767, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 32767, -32768, 32767, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 32767, -32768, 32767, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 32767, -32768, 32767, 1,
              32'h7fff0000, 32'h80000000, 32'h7fff0000);
      add_row(0, 0, 0, 0, -32768, 32767, -32768, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 32767, 32767, -32768, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, -32768, -32768, 32767, 0, 0, 0, 0);
      // new curve on a full window
      add_row(0, 0, 0, 1, 1, 2, 3, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, -1, -2, -3, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 100, -100, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 5, 5, 5, 0, 0, 0, 0);
      // new curve on a partly filled window
      add_row(0, 0, 0, 1, 7, 7, 7, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 8, 8, 8, 0, 0, 0, 0);
      add_row(0, 0, 0, 1, -9, 10, -11, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 12, -13, 14, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, -15, 16, -17, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 32767, -1, 0, 0, 0, 0, 0);
      // zero steps, zero step size, largest step times count
      add_row(1, 0, 4096, 0, 1000, -1000, 500, 0, 0, 0, 0);
      add_row(1, 5, 0, 0, -32768, 32767, -32768, 0, 0, 0, 0);
      add_row(1, 63, 65535, 0, 32767, -32768, 32767, 0, 0, 0, 0);
      add_row(1, 1, 65535, 0, -32768, 32767, -32768, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.cfg_set) begin
            wait_for_drain();
            set_config(row.cfg_count, row.cfg_size);
         end
         idle_source();
         send_point(row.new_curve, row.x, row.y, row.z, row.typed, row.tx, row.ty, row.tz);
      end

      while (random_items < RANDOM_ITEMS) begin
         wait_for_drain();
         r = $urandom_range(0, 99);
         if (r < 5) cnt = 0;
         else if (r < 75) cnt = $urandom_range(1, 8);
         else if (r < 90) cnt = $urandom_range(9, 24);
         else cnt = $urandom_range(25, 63);
         r = $urandom_range(0, 99);
         if (r < 70 && cnt != 0) begin
            sz = (65536 + cnt / 2) / cnt;
            if (sz > 65535) sz = 65535;
         end else if (r < 85) begin
            sz = $urandom_range(0, 65535);
         end else if (r < 95) begin
            sz = 65535;
         end else begin
            sz = 0;
         end
         set_config(cnt, sz);
         phase_items = $urandom_range(15, 35);
         while (phase_items > 0 && random_items < RANDOM_ITEMS) begin
            src_calm = ($urandom_range(0, 4) == 0);
            noise = ($urandom_range(0, 99) < 15);
            curve_len = noise ? $urandom_range(1, 4) : $urandom_range(4, 10);
            for (int i = 0; i < curve_len; i++) begin
               nc = noise ? logic'($urandom_range(0, 1)) : (i == 0);
               idle_source();
               send_point(nc, rand_coord(), rand_coord(), rand_coord(), 1'b0, 0, 0, 0);
               random_items++;
               phase_items--;
               // hold the source until every pending point is out
               if (!paused_once && random_items >= RANDOM_ITEMS / 2) begin
                  paused_once = 1'b1;
                  wait_for_drain();
               end
            end
         end
      end

      wait_for_drain();
      $display("sent %0d control points across %0d register settings plus reset values",
               items_sent, settings_used);
      $display("checked %0d curve points in %0d segments, %0d mismatches",
               points_checked, segments_seen, mismatch_count);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("bspline_forward_difference regression: pass");
      end else begin
         $display("bspline_forward_difference regression: fail");
      end
      $finish;
   end

endmodule
